// ===== src/lle_pkg.sv =====
// Shared constants, types and arithmetic helpers for the luma Laplacian edge filter.
// No dependencies; every other file in src refers to it by scoped names.
package lle_pkg;

   localparam int PIXEL_W         = 24;
   localparam int LUMA_W          = 8;
   localparam int FRAME_WIDTH_W   = 11;
   localparam int FRAME_HEIGHT_W  = 12;
   localparam int ROW_W           = 12;
   localparam int CSR_DATA_W      = 12;
   localparam int CSR_INDEX_W     = 1;
   localparam int WIN_TAPS        = 6;
   localparam int KSUM_W          = 12;   // signed kernel sum, -2040..2040

   localparam int DEFAULT_MAX_WIDTH = 1024;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd800;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd600;

   localparam logic [15:0] LUMA_R_COEF = 16'd77;
   localparam logic [15:0] LUMA_G_COEF = 16'd150;
   localparam logic [15:0] LUMA_B_COEF = 16'd29;

   localparam logic [LUMA_W-1:0] LUMA_MAX = 8'hff;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // line buffer port strobes
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } buf_ctrl_type;

   // Y = (77R + 150G + 29B) >> 8
   function automatic logic [LUMA_W-1:0] luma_of(input logic [PIXEL_W-1:0] pix);
      logic [15:0] acc;
      acc = LUMA_R_COEF * {8'd0, pix[23:16]}
          + LUMA_G_COEF * {8'd0, pix[15:8]}
          + LUMA_B_COEF * {8'd0, pix[7:0]};
      return acc[15:8];
   endfunction

   function automatic logic [LUMA_W-1:0] clamp_u8(input logic signed [KSUM_W-1:0] s);
      logic [LUMA_W-1:0] v;
      if (s[KSUM_W-1]) begin
         v = '0;
      end else if (s[KSUM_W-2:LUMA_W] != '0) begin
         v = LUMA_MAX;
      end else begin
         v = s[LUMA_W-1:0];
      end
      return v;
   endfunction

endpackage

// ===== src/lle_if.sv =====
// Stream channel interfaces (valid/ready plus pixel payload) for the edge filter.
// Depends on lle_pkg for the pixel width.
interface lle_req_if;
   logic                         valid;
   logic                         ready;
   logic [lle_pkg::PIXEL_W-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface lle_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lle_pkg::PIXEL_W-1:0]  pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== src/luma_laplacian_edge_filter.sv =====
// Top level of the luma Laplacian edge filter: config registers, raster counters.
// Depends on lle_pkg, lle_if.sv, lle_line_buf and lle_stage.
//
// Usage:
//  - req_bus carries one 24-bit RGB pixel per beat in raster order (R 23:16, G 15:8,
//    B 7:0); rsp_bus returns one beat per pixel, the clamped 8-center Laplacian of
//    luma replicated into R, G and B. Zero in the first two rows and columns.
//  - csr_we/csr_index/csr_wdata write frame_width (index 0) and frame_height
//    (index 1); write only while no beat is in flight.
//  - An accepted beat passes the working stage and the output register to rsp_bus.
//  - Throughput: one beat per cycle while rsp_bus.ready stays high. The line memories
//    are read at the accept edge and written as the beat leaves the working stage; a
//    same-address collision (one-pixel lines) is bypassed around the memory.
//  - Stall: a held result keeps the output register; the working stage then holds
//    one more beat and req_bus.ready drops until rsp_bus.ready returns.
//  - Reset: counters and window cleared, size back to 800x600, no beats in flight.
//    Line memories are not cleared; the first two rows never read stale data into
//    a visible result.
module luma_laplacian_edge_filter #(
   parameter int MAX_WIDTH = lle_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   lle_req_if.sink                            req_bus,
   lle_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [lle_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lle_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ColW = $clog2(MAX_WIDTH);
   // compare width: holds the width register and MAX_WIDTH
   localparam int CmpW = (ColW + 1 > lle_pkg::FRAME_WIDTH_W) ? ColW + 1
                                                            : lle_pkg::FRAME_WIDTH_W;

   logic [lle_pkg::FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [lle_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [ColW-1:0]                    col_ff, col_in;
   logic [lle_pkg::ROW_W-1:0]          row_ff, row_in;

   logic [CmpW-1:0]                    width_ext, line_limit, col_next;
   logic [lle_pkg::ROW_W:0]            row_next;
   logic                               border;

   lle_pkg::buf_ctrl_type              buf_ctrl;
   logic [ColW-1:0]                    wr_addr;
   logic [lle_pkg::LUMA_W-1:0]         wr_older, wr_newer, buf_older, buf_newer;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lle_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= lle_pkg::FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            lle_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[lle_pkg::FRAME_WIDTH_W-1:0];
            end
            lle_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[lle_pkg::FRAME_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // width of 0 or beyond the line memory means a full-depth line
   always_comb begin
      width_ext  = CmpW'(frame_width_ff);
      line_limit = (width_ext == '0 || width_ext > CmpW'(MAX_WIDTH)) ? CmpW'(MAX_WIDTH)
                                                                  : width_ext;
      col_next   = CmpW'(col_ff) + CmpW'(1);
      row_next   = {1'b0, row_ff} + (lle_pkg::ROW_W + 1)'(1);
      col_in     = col_ff;
      row_in     = row_ff;
      if (col_next >= line_limit) begin
         col_in = '0;
         // height 0 lets the row counter roll over on its own
         if (frame_height_ff != '0 && row_next >= {1'b0, frame_height_ff}) begin
            row_in = '0;
         end else begin
            row_in = row_next[lle_pkg::ROW_W-1:0];
         end
      end else begin
         col_in = col_next[ColW-1:0];
      end
   end

   assign border = (col_ff < ColW'(2)) || (row_ff < lle_pkg::ROW_W'(2));

   // raster position advances on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (buf_ctrl.rd_en) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   lle_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock    (clock),
      .ctrl     (buf_ctrl),
      .rd_addr  (col_ff),
      .wr_addr  (wr_addr),
      .wr_older (wr_older),
      .wr_newer (wr_newer),
      .rd_older (buf_older),
      .rd_newer (buf_newer)
   );

   lle_stage #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_stage (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .col       (col_ff),
      .border    (border),
      .buf_older (buf_older),
      .buf_newer (buf_newer),
      .buf_ctrl  (buf_ctrl),
      .wr_addr   (wr_addr),
      .wr_older  (wr_older),
      .wr_newer  (wr_newer)
   );

endmodule

// ===== src/lle_line_buf.sv =====
// Two luma line memories (one and two lines back) with registered reads.
// Depends on lle_pkg; forwards a write that lands on the address read in the same cycle.
module lle_line_buf #(
   parameter int MAX_WIDTH = lle_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                        clock,
   input  lle_pkg::buf_ctrl_type       ctrl,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [lle_pkg::LUMA_W-1:0]  wr_older,
   input  logic [lle_pkg::LUMA_W-1:0]  wr_newer,
   output logic [lle_pkg::LUMA_W-1:0]  rd_older,
   output logic [lle_pkg::LUMA_W-1:0]  rd_newer
);

   logic [lle_pkg::LUMA_W-1:0] older_mem [MAX_WIDTH];
   logic [lle_pkg::LUMA_W-1:0] newer_mem [MAX_WIDTH];

   logic [lle_pkg::LUMA_W-1:0] older_q_ff;
   logic [lle_pkg::LUMA_W-1:0] newer_q_ff;
   logic [lle_pkg::LUMA_W-1:0] fwd_older_ff;
   logic [lle_pkg::LUMA_W-1:0] fwd_newer_ff;
   logic                       fwd_sel_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         older_mem[wr_addr] <= wr_older;
         newer_mem[wr_addr] <= wr_newer;
      end
   end

   // read-first memory; a same-address write is taken from the bypass
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         older_q_ff   <= older_mem[rd_addr];
         newer_q_ff   <= newer_mem[rd_addr];
         fwd_sel_ff   <= ctrl.wr_en && (wr_addr == rd_addr);
         fwd_older_ff <= wr_older;
         fwd_newer_ff <= wr_newer;
      end
   end

   assign rd_older = fwd_sel_ff ? fwd_older_ff : older_q_ff;
   assign rd_newer = fwd_sel_ff ? fwd_newer_ff : newer_q_ff;

endmodule

// ===== src/lle_stage.sv =====
// Working stage and result register: luma, 3x3 window, Laplacian, clamp.
// Depends on lle_pkg and the channel interfaces in lle_if.sv.
module lle_stage #(
   parameter int MAX_WIDTH = lle_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   lle_req_if.sink                      req_bus,
   lle_rsp_if.source                    rsp_bus,
   input  logic [$clog2(MAX_WIDTH)-1:0] col,
   input  logic                         border,
   input  logic [lle_pkg::LUMA_W-1:0]   buf_older,
   input  logic [lle_pkg::LUMA_W-1:0]   buf_newer,
   output lle_pkg::buf_ctrl_type        buf_ctrl,
   output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   output logic [lle_pkg::LUMA_W-1:0]   wr_older,
   output logic [lle_pkg::LUMA_W-1:0]   wr_newer
);

   localparam int ColW = $clog2(MAX_WIDTH);

   logic                          s1_valid_ff, s1_valid_in;
   logic [lle_pkg::PIXEL_W-1:0]   s1_pix_ff;
   logic                          s1_border_ff;
   logic [ColW-1:0]               s1_col_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lle_pkg::PIXEL_W-1:0]   rsp_pix_ff, rsp_pix_in;
   logic [lle_pkg::LUMA_W-1:0]    win_ff [lle_pkg::WIN_TAPS];
   logic [lle_pkg::LUMA_W-1:0]    win_in [lle_pkg::WIN_TAPS];

   logic                          out_free, s1_adv, accept;
   logic [lle_pkg::LUMA_W-1:0]    y;
   logic [lle_pkg::LUMA_W+2:0]    nsum;
   logic signed [lle_pkg::KSUM_W-1:0] ksum;
   logic [lle_pkg::LUMA_W-1:0]    mag;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign accept   = req_bus.valid && req_bus.ready;

   assign buf_ctrl.rd_en = accept;
   assign buf_ctrl.wr_en = s1_adv;

   assign y = lle_pkg::luma_of(s1_pix_ff);

   // window taps: pairs (column before last, last column) for oldest, middle, current line
   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = buf_older;
      win_in[2] = win_ff[3];
      win_in[3] = buf_newer;
      win_in[4] = win_ff[5];
      win_in[5] = y;
   end

   always_comb begin
      nsum = 11'(win_ff[0]) + 11'(win_ff[1]) + 11'(buf_older)
           + 11'(win_ff[2]) + 11'(buf_newer)
           + 11'(win_ff[4]) + 11'(win_ff[5]) + 11'(y);
      ksum = $signed({1'b0, win_ff[3], 3'b000}) - $signed({1'b0, nsum});
      mag  = lle_pkg::clamp_u8(ksum);
      rsp_pix_in = s1_border_ff ? '0 : {mag, mag, mag};
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_bus.ready);

   assign wr_addr  = s1_col_ff;
   assign wr_older = buf_newer;
   assign wr_newer = y;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < lle_pkg::WIN_TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            for (int i = 0; i < lle_pkg::WIN_TAPS; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= req_bus.pixel_in;
         s1_border_ff <= border;
         s1_col_ff    <= col;
      end
      if (s1_adv) begin
         rsp_pix_ff <= rsp_pix_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pixel_out = rsp_pix_ff;

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat did not reach the working stage");

   a_stage_to_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("stage advanced but no result registered");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_pix_ff)))
      else $error("stalled stage lost its beat");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_border_ff) |=> (rsp_pix_ff == '0))
      else $error("border pixel produced nonzero output");

endmodule

// ===== dv/edge_filter_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the luma Laplacian edge filter: predicts each result beat and compares.
// Depends on lle_pkg and the channel interfaces in lle_if.sv; watches the csr port too.
module edge_filter_checker
   import lle_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   lle_req_if                      req_mon,
   lle_rsp_if                      rsp_mon,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      fail_count,
   output int                      pending
);

   localparam int LINE_DEPTH = DEFAULT_MAX_WIDTH;
   localparam int PRINT_CAP  = 30;

   logic [LUMA_W-1:0]         two_back [LINE_DEPTH];
   logic [LUMA_W-1:0]         one_back [LINE_DEPTH];
   logic [LUMA_W-1:0]         win_taps [WIN_TAPS];
   logic [FRAME_WIDTH_W-1:0]  width_reg;
   logic [FRAME_HEIGHT_W-1:0] height_reg;
   int unsigned               col_pos;
   int unsigned               row_pos;
   logic [PIXEL_W-1:0]        predicted_edges [$];

   function automatic logic [LUMA_W-1:0] rgb_to_luma(input logic [PIXEL_W-1:0] pix);
      int unsigned acc;
      acc = 77 * pix[23:16] + 150 * pix[15:8] + 29 * pix[7:0];
      return LUMA_W'(acc >> 8);
   endfunction

   task automatic flag_mismatch(input string msg);
      if (fail_count < PRINT_CAP) $display("[%0t] edge check: %s", $time, msg);
      fail_count++;
   endtask

   // 3x3 window built from two window columns plus the fresh column
   task automatic predict_edge(input logic [PIXEL_W-1:0] pix);
      int unsigned       slot;
      int unsigned       lim;
      int unsigned       nxt;
      int                nb [3][3];
      int                acc;
      logic [LUMA_W-1:0] y;
      logic [LUMA_W-1:0] mag;
      slot = col_pos % LINE_DEPTH;
      y = rgb_to_luma(pix);
      for (int k = 0; k < 3; k++) begin
         nb[k][0] = win_taps[2*k];
         nb[k][1] = win_taps[2*k+1];
      end
      nb[0][2] = two_back[slot];
      nb[1][2] = one_back[slot];
      nb[2][2] = y;
      for (int k = 0; k < 3; k++) begin
         win_taps[2*k]   = LUMA_W'(nb[k][1]);
         win_taps[2*k+1] = LUMA_W'(nb[k][2]);
      end
      two_back[slot] = one_back[slot];
      one_back[slot] = y;

      // 8*center minus neighbors == 9*center minus all nine
      acc = 9 * nb[1][1];
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            acc -= nb[r][c];
      if (acc < 0) mag = '0;
      else if (acc > 255) mag = 8'hff;
      else mag = LUMA_W'(acc);

      if (col_pos < 2 || row_pos < 2) predicted_edges.push_back('0);
      else predicted_edges.push_back({mag, mag, mag});

      lim = (width_reg == 0 || width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
      nxt = col_pos + 1;
      if (nxt >= lim) begin
         col_pos = 0;
         nxt = row_pos + 1;
         if (height_reg != 0 && nxt >= height_reg) nxt = 0;
         row_pos = nxt & 32'hfff;
      end else begin
         col_pos = nxt;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (two_back[i]) two_back[i] = '0;
         foreach (one_back[i]) one_back[i] = '0;
         foreach (win_taps[i]) win_taps[i] = '0;
         width_reg  = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         col_pos    = 0;
         row_pos    = 0;
         fail_count = 0;
         predicted_edges.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_FRAME_WIDTH:  width_reg  = csr_wdata[FRAME_WIDTH_W-1:0];
               CSR_FRAME_HEIGHT: height_reg = csr_wdata[FRAME_HEIGHT_W-1:0];
               default: ;
            endcase
         end
         // result side first: a beat never leaves in its own accept cycle
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (predicted_edges.size() == 0) begin
               flag_mismatch($sformatf("result beat %06h with no pixel outstanding",
                                       rsp_mon.pixel_out));
            end else if (rsp_mon.pixel_out !== predicted_edges[0]) begin
               flag_mismatch($sformatf("pixel_out %06h, predicted %06h",
                                       rsp_mon.pixel_out, predicted_edges[0]));
               void'(predicted_edges.pop_front());
            end else begin
               void'(predicted_edges.pop_front());
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) predict_edge(req_mon.pixel_in);
      end
      pending = predicted_edges.size();
   end

endmodule

// ===== dv/luma_laplacian_edge_filter_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the luma Laplacian edge filter: clock, reset, pixel stimulus, verdict.
// Depends on lle_pkg, lle_if.sv, the filter RTL and edge_filter_checker.
module luma_laplacian_edge_filter_tb;
   import lle_pkg::*;

   localparam int CYCLE_LIMIT  = 800_000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int TAIL_CYCLES  = 8;
   // widest line used once the line memories are filled
   localparam int FILL_WIDTH   = 80;

   // Directed frame at width 3: rows 0..7, three pixels each. Visible results only
   // at column 2 of rows 2 and up, so the rows are arranged around those windows.
   localparam logic [PIXEL_W-1:0] PROBE_PIXELS [24] = '{
      24'h000000, 24'h000000, 24'h000000,
      24'h000000, 24'hffffff, 24'h000000,   // lone white center
      24'h000000, 24'h000000, 24'h000000,   // -> clamp high
      24'hffffff, 24'hffffff, 24'hffffff,   // dark center, white ring -> clamp low
      24'hff0000, 24'h00ff00, 24'h0000ff,   // pure channels
      24'h808080, 24'h7f7f7f, 24'h010203,
      24'h102030, 24'h405060, 24'h708090,
      24'hffffff, 24'h000000, 24'hffffff
   };

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   csr_index_type            csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   int                       fail_count;
   int                       pending;

   int                       burst_left;
   logic [PIXEL_W-1:0]       smooth_base;
   logic                     hold_due;

   lle_req_if req_bus ();
   lle_rsp_if rsp_bus ();

   luma_laplacian_edge_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   edge_filter_checker edge_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Pixel content. Mode 0: uniform noise (mostly clamped results). Mode 1: slow
   // drift per channel, so the kernel lands mid-range. Mode 2: sparse black/white.
   function automatic logic [PIXEL_W-1:0] texture_pixel(input int mode);
      int                 ch;
      logic [PIXEL_W-1:0] p;
      case (mode)
         0: p = PIXEL_W'($urandom);
         1: begin
            for (int k = 0; k < 3; k++) begin
               ch = int'(smooth_base[8*k +: 8]) + int'($urandom_range(0, 8)) - 4;
               if (ch < 0) ch = 0;
               if (ch > 255) ch = 255;
               smooth_base[8*k +: 8] = 8'(ch);
            end
            p = smooth_base;
         end
         default: begin
            if ($urandom_range(0, 3) == 0) p = 24'hffffff;
            else if ($urandom_range(0, 5) == 0) p = PIXEL_W'($urandom);
            else p = 24'h000000;
         end
      endcase
      return p;
   endfunction

   // One beat; held until accepted. Bursts of random length, random gaps between.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      int gap;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 16);
      end
      req_bus.valid    <= 1'b1;
      req_bus.pixel_in <= pix;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      burst_left--;
   endtask

   // Stop offering and wait until every result is back; ends on a rising edge.
   // Every beat yields a result, so an empty prediction queue means an idle block.
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // width MSB of the 12-bit data word is junk for the 11-bit register; toggle it
   task automatic set_frame(input int w, input int h, input bit do_w, input bit do_h);
      if (do_w) write_reg(CSR_FRAME_WIDTH, {1'($urandom_range(0, 1)), 11'(w)});
      if (do_h) write_reg(CSR_FRAME_HEIGHT, 12'(h));
      csr_we <= 1'b0;
   endtask

   // Receiver: segments of always-ready, coin flips, a fixed 3-of-4 pattern,
   // mostly-ready and dead stretches. One long hold-off on request while the
   // sender keeps pushing, so the working stage fills and req ready drops.
   initial begin
      int seg_len;
      int kind;
      int hold_cycles;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_due) begin
            hold_due = 1'b0;
            hold_cycles = $urandom_range(60, 120);
            rsp_bus.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
         end
         kind    = $urandom_range(0, 4);
         seg_len = $urandom_range(8, 64);
         for (int c = 0; c < seg_len; c++) begin
            case (kind)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (c % 4 != 3);
               3: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               default: rsp_bus.ready <= (c >= seg_len / 2);
            endcase
            @(posedge clock);
         end
      end
   end

   // Watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int n;
      int w;
      int h;
      int mode;
      int k;
      int random_sent;
      bit do_w;
      bit do_h;

      req_bus.valid    <= 1'b0;
      req_bus.pixel_in <= '0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_FRAME_WIDTH;
      csr_wdata        <= '0;
      reset            <= 1'b1;
      burst_left  = 0;
      hold_due    = 1'b0;
      smooth_base = 24'h808080;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: three-pixel line, tallest frame. Ends at row 8, column 0.
      set_frame(3, 4095, 1'b1, 1'b1);
      foreach (PROBE_PIXELS[i]) send_pixel(PROBE_PIXELS[i]);

      // Height dropped below the current row: row 8 is still visible, then the
      // row counter wraps to 0 on the next line end.
      settle();
      set_frame(0, 3, 1'b0, 1'b1);
      send_pixel(24'h123456);
      send_pixel(24'hfedcba);
      send_pixel(24'h000001);

      // One 3-line frame at the widest line used later: rows 0 and 1 are border,
      // so both line memories hold real data at every address before any later
      // line can show it. Long receiver hold-off lands in this stretch.
      settle();
      set_frame(FILL_WIDTH, 0, 1'b1, 1'b0);
      hold_due = 1'b1;
      mode = 0;
      for (int i = 0; i < 3 * FILL_WIDTH; i++) begin
         if (i % 64 == 0) mode = $urandom_range(0, 2);
         send_pixel(texture_pixel(mode));
      end

      // Height 0: no configured wrap, rows 3 and 4 stay visible.
      settle();
      set_frame(3, 0, 1'b1, 1'b1);
      for (int i = 0; i < 15; i++) send_pixel(texture_pixel(i % 3));

      // Random phases: settings picked per phase, often mid-line and mid-frame.
      // The first few pin the odd corners (1- and 2-pixel lines, 1- and 2-line
      // frames, the widest filled line).
      random_sent = 0;
      k = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         do_w = 1'b1;
         do_h = 1'b1;
         case (k)
            0: begin w = FILL_WIDTH; h = 0;    n = 150; end
            1: begin w = 1;          h = 5;    n = 20;  end
            2: begin w = 2;          h = 4;    n = 30;  end
            3: begin w = 4;          h = 1;    n = 30;  end
            4: begin w = 5;          h = 2;    n = 30;  end
            5: begin w = 3;          h = 4095; n = 40;  end
            6: begin w = FILL_WIDTH; h = 3;    n = 100; end
            default: begin
               case ($urandom_range(0, 19))
                  0, 1, 2:    w = $urandom_range(1, 2);
                  3, 4, 5:    w = $urandom_range(13, FILL_WIDTH);
                  6, 7:       w = $urandom_range(1, FILL_WIDTH);
                  default:    w = $urandom_range(3, 12);
               endcase
               case ($urandom_range(0, 19))
                  0, 1, 2:    h = $urandom_range(0, 2);
                  3, 4, 5:    h = $urandom_range(9, 4095);
                  6, 7:       h = 4095;
                  default:    h = $urandom_range(3, 8);
               endcase
               n = $urandom_range(10, 120);
               do_w = 1'($urandom_range(0, 3) != 0);
               do_h = 1'($urandom_range(0, 3) != 0);
            end
         endcase
         set_frame(w, h, do_w, do_h);
         mode = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) begin
            if (i % 48 == 47) mode = $urandom_range(0, 2);
            send_pixel(texture_pixel(mode));
         end
         random_sent += n;
         k++;
      end

      // Drain, then idle through the tail for stray results.
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
